FILE: hdl/esv_pkg.sv
// Shared types and constants for the ElGamal signature engine.
`timescale 1ns / 1ps
package esv_pkg;

   // Sequencer states of the top level.
   typedef enum logic [4:0] {
      S_IDLE,
      S_CHECK,
      S_INV_RED,
      S_INV_TEST,
      S_INV_DIV,
      S_INV_MUL,
      S_POW_RED,
      S_POW_STEP,
      S_POW_ACC,
      S_POW_SQ,
      S_S_X1,
      S_S_A,
      S_S_D,
      S_S_B,
      S_S_O2,
      S_V_E2,
      S_V_V1,
      S_V_PA,
      S_V_PB,
      S_V_CMP,
      S_RESP
   } seq_state_type;

   // States of the serial arithmetic unit.
   typedef enum logic [1:0] {
      U_IDLE,
      U_MUL,
      U_DIV,
      U_DONE
   } unit_state_type;

   typedef enum logic {
      OP_MUL,
      OP_DIV
   } unit_op_type;

   typedef struct packed {
      logic        start;
      unit_op_type op;
   } unit_cmd_type;

   localparam logic [2:0] ST_SIGNED = 3'd0;
   localparam logic [2:0] ST_ACCEPT = 3'd1;
   localparam logic [2:0] ST_DENY   = 3'd2;
   localparam logic [2:0] ST_RANGE  = 3'd3;
   localparam logic [2:0] ST_NONCE  = 3'd4;

   localparam logic OPC_SIGN   = 1'b0;
   localparam logic OPC_VERIFY = 1'b1;

   localparam logic [1:0] CSR_MODULUS   = 2'd0;
   localparam logic [1:0] CSR_GENERATOR = 2'd1;
   localparam logic [1:0] CSR_PRIV_EXP  = 2'd2;
   localparam logic [1:0] CSR_NONCE     = 2'd3;

   localparam logic [31:0] RST_MODULUS   = 32'd2147483647;
   localparam logic [31:0] RST_GENERATOR = 32'd2;
   localparam logic [31:0] RST_PRIV_EXP  = 32'd127;
   localparam logic [31:0] RST_NONCE     = 32'd307;

endpackage

FILE: hdl/esv_serial_unit.sv
// Bit-serial modular multiplier and restoring divider shared by the sequencer.
`timescale 1ns / 1ps
module esv_serial_unit #(
   parameter int N = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  esv_pkg::unit_cmd_type cmd,
   input  logic [N-1:0]         opa,
   input  logic [N-1:0]         opb,
   input  logic [N-1:0]         opm,
   output logic                 done,
   output logic [N-1:0]         res,
   output logic [N-1:0]         quo
);
   import esv_pkg::*;

   localparam int CW = $clog2(N + 1);

   unit_state_type state_ff, state_in;
   logic [N-1:0]   acc_ff, x_ff, y_ff, m_ff;
   logic [CW-1:0]  cnt_ff;

   logic [N:0]     acc_sum, x_sum, rem_sh;
   logic [N-1:0]   acc_add, x_add;
   logic           rem_ge;

   // modular add: operands stay below the modulus
   always_comb begin
      acc_sum = {1'b0, acc_ff} + {1'b0, x_ff};
      x_sum   = {1'b0, x_ff} + {1'b0, x_ff};
      acc_add = (acc_sum >= {1'b0, m_ff}) ? acc_sum[N-1:0] - m_ff : acc_sum[N-1:0];
      x_add   = (x_sum >= {1'b0, m_ff}) ? x_sum[N-1:0] - m_ff : x_sum[N-1:0];
      rem_sh  = {acc_ff, y_ff[N-1]};
      rem_ge  = (rem_sh >= {1'b0, m_ff});
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         U_IDLE, U_DONE: begin
            if (cmd.start) state_in = (cmd.op == OP_MUL) ? U_MUL : U_DIV;
            else state_in = U_IDLE;
         end
         U_MUL: begin
            if (y_ff == '0) state_in = U_DONE;
         end
         U_DIV: begin
            if (cnt_ff == CW'(1)) state_in = U_DONE;
         end
         default: state_in = U_IDLE;
      endcase
   end

   always_comb begin
      done = (state_ff == U_DONE);
      res  = acc_ff;
      quo  = y_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         U_IDLE, U_DONE: begin
            if (cmd.start) begin
               acc_ff <= '0;
               if (cmd.op == OP_MUL) begin
                  x_ff <= opa;
                  y_ff <= opb;
                  m_ff <= opm;
               end else begin
                  y_ff <= opa;
                  m_ff <= opb;
               end
               cnt_ff <= CW'(N);
            end
         end
         U_MUL: begin
            if (y_ff != '0) begin
               if (y_ff[0]) acc_ff <= acc_add;
               x_ff <= x_add;
               y_ff <= {1'b0, y_ff[N-1:1]};
            end
         end
         U_DIV: begin
            acc_ff <= rem_ge ? rem_sh[N-1:0] - m_ff : rem_sh[N-1:0];
            y_ff   <= {y_ff[N-2:0], rem_ge};
            cnt_ff <= cnt_ff - CW'(1);
         end
         default: ;
      endcase
   end

endmodule

FILE: hdl/elgamal_sign_verify.sv
// Top level of the ElGamal signature engine: sequencer, operand registers, ports.
`timescale 1ns / 1ps
// ElGamal sign and verify engine over the group of integers modulo a prime p.
// A sign word (opcode 0) returns s1 = g^r mod p and s2 = (M - d*s1) * r^-1
// mod (p-1) with status 0, or status 4 when r has no inverse mod p-1 (or p
// is below three). A verify word (opcode 1) range-checks (s1, s2), answering
// status 3 on failure, and otherwise answers 1 or 2 depending on whether
// g^M equals (g^d)^s1 * s1^s2 mod p. Exactly one result word follows each
// request word; out_first and out_second are zero except after a good sign.
// Items are handled one at a time. All arithmetic runs through a single
// bit-serial unit: a modular multiply handles one multiplier bit per cycle
// and a remainder one quotient bit per cycle. A verify takes four
// exponentiations, a sign extended Euclid on the nonce, one exponentiation
// and two multiplies. Configuration registers are written through the csr_
// port, which is always ready; write them only while no request is in flight.
module elgamal_sign_verify #(
   parameter int MOD_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [31:0] req_message,
   input  logic [31:0] req_sig_first,
   input  logic [31:0] req_sig_second,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_out_first,
   output logic [31:0] rsp_out_second,
   // configuration channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import esv_pkg::*;

   localparam int N = MOD_BITS;

   // Fit a 32-bit word to the internal width (truncate or zero-extend).
   function automatic logic [N-1:0] fit_in(input logic [31:0] v);
      logic [N+31:0] e;
      e = {{N{1'b0}}, v};
      return e[N-1:0];
   endfunction

   // Fit an internal value to a 32-bit result field.
   function automatic logic [31:0] fit_out(input logic [N-1:0] v);
      logic [N+31:0] e;
      e = {32'd0, v};
      return e[31:0];
   endfunction

   // (a - b) mod m with a, b below m
   function automatic logic [N-1:0] sub_mod(input logic [N-1:0] a, input logic [N-1:0] b,
                                            input logic [N-1:0] m);
      return (a >= b) ? a - b : a + (m - b);
   endfunction

   // Configuration registers.
   logic [N-1:0] modulus_ff, generator_ff, priv_exp_ff, nonce_ff;

   // Request capture.
   logic         op_ff;
   logic [N-1:0] msg_ff, s1_ff, s2_ff;

   // Working registers.
   seq_state_type state_ff, state_in, ret_ff;
   logic [N-1:0]  pm1_ff;
   logic [N-1:0]  base_ff, exp_ff, acc_ff;
   logic [N-1:0]  r0_ff, r1_ff, t0_ff, t1_ff, rinv_ff;
   logic [N-1:0]  x1_ff, a_ff, e2_ff, v1_ff, pa_ff;

   // Result registers.
   logic [2:0]    status_ff;
   logic [N-1:0]  first_ff, second_ff;

   // Serial unit interface.
   unit_cmd_type  unit_cmd;
   logic [N-1:0]  unit_a, unit_b, unit_m;
   logic          unit_done;
   logic [N-1:0]  unit_res, unit_quo;

   // Derived values.
   logic          p_small, range_bad;
   logic [N-1:0]  p_m1, qm, xm;

   always_comb begin
      p_small   = (modulus_ff < N'(3));
      p_m1      = modulus_ff - N'(1);
      range_bad = p_small || (s1_ff == '0) || (s1_ff >= modulus_ff) ||
                  (s2_ff == '0) || (s2_ff >= p_m1);
      // quotient never exceeds p-1, so one subtract reduces it
      qm        = (unit_quo >= pm1_ff) ? unit_quo - pm1_ff : unit_quo;
      // s1 is below p, so one subtract reduces it mod p-1
      xm        = (x1_ff >= pm1_ff) ? x1_ff - pm1_ff : x1_ff;
   end

   esv_serial_unit #(
      .N(N)
   ) u_unit (
      .clock (clock),
      .reset (reset),
      .cmd   (unit_cmd),
      .opa   (unit_a),
      .opb   (unit_b),
      .opm   (unit_m),
      .done  (unit_done),
      .res   (unit_res),
      .quo   (unit_quo)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_CHECK;
         end
         S_CHECK: begin
            if (op_ff == OPC_SIGN) state_in = p_small ? S_RESP : S_INV_RED;
            else state_in = range_bad ? S_RESP : S_POW_RED;
         end
         S_INV_RED: begin
            if (unit_done) state_in = S_INV_TEST;
         end
         S_INV_TEST: begin
            if (r1_ff != '0) state_in = S_INV_DIV;
            else if (r0_ff == N'(1)) state_in = S_POW_RED;
            else state_in = S_RESP;
         end
         S_INV_DIV: begin
            if (unit_done) state_in = S_INV_MUL;
         end
         S_INV_MUL: begin
            if (unit_done) state_in = S_INV_TEST;
         end
         S_POW_RED: begin
            if (unit_done) state_in = S_POW_STEP;
         end
         S_POW_STEP: begin
            if (exp_ff == '0) state_in = ret_ff;
            else if (exp_ff[0]) state_in = S_POW_ACC;
            else state_in = S_POW_SQ;
         end
         S_POW_ACC: begin
            if (unit_done) state_in = S_POW_SQ;
         end
         S_POW_SQ: begin
            if (unit_done) state_in = S_POW_STEP;
         end
         S_S_X1: state_in = S_S_A;
         S_S_A: begin
            if (unit_done) state_in = S_S_D;
         end
         S_S_D: begin
            if (unit_done) state_in = S_S_B;
         end
         S_S_B: begin
            if (unit_done) state_in = S_S_O2;
         end
         S_S_O2: begin
            if (unit_done) state_in = S_RESP;
         end
         S_V_E2, S_V_V1, S_V_PA: state_in = S_POW_RED;
         S_V_PB: state_in = S_V_CMP;
         S_V_CMP: begin
            if (unit_done) state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs: handshakes and serial unit launches.
   always_comb begin
      req_ready      = (state_ff == S_IDLE);
      rsp_valid      = (state_ff == S_RESP);
      csr_ready      = 1'b1;
      rsp_status     = status_ff;
      rsp_out_first  = fit_out(first_ff);
      rsp_out_second = fit_out(second_ff);
      unit_cmd.start = 1'b0;
      unit_cmd.op    = OP_MUL;
      unit_a         = '0;
      unit_b         = '0;
      unit_m         = modulus_ff;
      case (state_ff)
         S_CHECK: begin
            if (op_ff == OPC_SIGN && !p_small) begin
               // reduce the nonce mod p-1 to seed Euclid
               unit_cmd = '{start: 1'b1, op: OP_DIV};
               unit_a   = nonce_ff;
               unit_b   = p_m1;
            end else if (op_ff == OPC_VERIFY && !range_bad) begin
               unit_cmd = '{start: 1'b1, op: OP_DIV};
               unit_a   = generator_ff;
               unit_b   = modulus_ff;
            end
         end
         S_INV_TEST: begin
            if (r1_ff != '0) begin
               unit_cmd = '{start: 1'b1, op: OP_DIV};
               unit_a   = r0_ff;
               unit_b   = r1_ff;
            end else if (r0_ff == N'(1)) begin
               unit_cmd = '{start: 1'b1, op: OP_DIV};
               unit_a   = generator_ff;
               unit_b   = modulus_ff;
            end
         end
         S_INV_DIV: begin
            if (unit_done) begin
               unit_cmd = '{start: 1'b1, op: OP_MUL};
               unit_a   = qm;
               unit_b   = t1_ff;
               unit_m   = pm1_ff;
            end
         end
         S_POW_STEP: begin
            if (exp_ff != '0) begin
               unit_cmd = '{start: 1'b1, op: OP_MUL};
               unit_a   = exp_ff[0] ? acc_ff : base_ff;
               unit_b   = base_ff;
            end
         end
         S_POW_ACC: begin
            if (unit_done) begin
               unit_cmd = '{start: 1'b1, op: OP_MUL};
               unit_a   = base_ff;
               unit_b   = base_ff;
            end
         end
         S_S_X1: begin
            unit_cmd = '{start: 1'b1, op: OP_DIV};
            unit_a   = msg_ff;
            unit_b   = pm1_ff;
         end
         S_S_A: begin
            if (unit_done) begin
               unit_cmd = '{start: 1'b1, op: OP_DIV};
               unit_a   = priv_exp_ff;
               unit_b   = pm1_ff;
            end
         end
         S_S_D: begin
            if (unit_done) begin
               unit_cmd = '{start: 1'b1, op: OP_MUL};
               unit_a   = unit_res;
               unit_b   = xm;
               unit_m   = pm1_ff;
            end
         end
         S_S_B: begin
            if (unit_done) begin
               unit_cmd = '{start: 1'b1, op: OP_MUL};
               unit_a   = sub_mod(a_ff, unit_res, pm1_ff);
               unit_b   = rinv_ff;
               unit_m   = pm1_ff;
            end
         end
         S_V_E2: begin
            unit_cmd = '{start: 1'b1, op: OP_DIV};
            unit_a   = generator_ff;
            unit_b   = modulus_ff;
         end
         S_V_V1: begin
            unit_cmd = '{start: 1'b1, op: OP_DIV};
            unit_a   = e2_ff;
            unit_b   = modulus_ff;
         end
         S_V_PA: begin
            unit_cmd = '{start: 1'b1, op: OP_DIV};
            unit_a   = s1_ff;
            unit_b   = modulus_ff;
         end
         S_V_PB: begin
            unit_cmd = '{start: 1'b1, op: OP_MUL};
            unit_a   = pa_ff;
            unit_b   = acc_ff;
         end
         default: ;
      endcase
   end

   // Control state and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         modulus_ff   <= fit_in(RST_MODULUS);
         generator_ff <= fit_in(RST_GENERATOR);
         priv_exp_ff  <= fit_in(RST_PRIV_EXP);
         nonce_ff     <= fit_in(RST_NONCE);
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MODULUS:   modulus_ff   <= fit_in(csr_wdata);
               CSR_GENERATOR: generator_ff <= fit_in(csr_wdata);
               CSR_PRIV_EXP:  priv_exp_ff  <= fit_in(csr_wdata);
               CSR_NONCE:     nonce_ff     <= fit_in(csr_wdata);
               default: ;
            endcase
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_ff  <= req_opcode;
               msg_ff <= fit_in(req_message);
               s1_ff  <= fit_in(req_sig_first);
               s2_ff  <= fit_in(req_sig_second);
            end
         end
         S_CHECK: begin
            pm1_ff    <= p_m1;
            first_ff  <= '0;
            second_ff <= '0;
            if (op_ff == OPC_SIGN) begin
               status_ff <= ST_NONCE;
            end else begin
               status_ff <= ST_RANGE;
               exp_ff    <= priv_exp_ff;
               ret_ff    <= S_V_E2;
            end
         end
         S_INV_RED: begin
            if (unit_done) begin
               r0_ff <= pm1_ff;
               r1_ff <= unit_res;
               t0_ff <= '0;
               t1_ff <= N'(1);
            end
         end
         S_INV_TEST: begin
            if (r1_ff == '0) begin
               rinv_ff <= t0_ff;
               exp_ff  <= nonce_ff;
               ret_ff  <= S_S_X1;
            end
         end
         S_INV_DIV: begin
            if (unit_done) begin
               r0_ff <= r1_ff;
               r1_ff <= unit_res;
            end
         end
         S_INV_MUL: begin
            if (unit_done) begin
               t0_ff <= t1_ff;
               t1_ff <= sub_mod(t0_ff, unit_res, pm1_ff);
            end
         end
         S_POW_RED: begin
            if (unit_done) begin
               base_ff <= unit_res;
               acc_ff  <= N'(1);
            end
         end
         S_POW_ACC: begin
            if (unit_done) acc_ff <= unit_res;
         end
         S_POW_SQ: begin
            if (unit_done) begin
               base_ff <= unit_res;
               exp_ff  <= {1'b0, exp_ff[N-1:1]};
            end
         end
         S_S_X1: x1_ff <= acc_ff;
         S_S_A: begin
            if (unit_done) a_ff <= unit_res;
         end
         S_S_O2: begin
            if (unit_done) begin
               status_ff <= ST_SIGNED;
               first_ff  <= x1_ff;
               second_ff <= unit_res;
            end
         end
         S_V_E2: begin
            e2_ff  <= acc_ff;
            exp_ff <= msg_ff;
            ret_ff <= S_V_V1;
         end
         S_V_V1: begin
            v1_ff  <= acc_ff;
            exp_ff <= s1_ff;
            ret_ff <= S_V_PA;
         end
         S_V_PA: begin
            pa_ff  <= acc_ff;
            exp_ff <= s2_ff;
            ret_ff <= S_V_PB;
         end
         S_V_CMP: begin
            if (unit_done) status_ff <= (unit_res == v1_ff) ? ST_ACCEPT : ST_DENY;
         end
         default: ;
      endcase
   end

   // Never take a request while a result is still offered.
   a_ready_excl: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid)
      else $error("request taken while result pending");

   // Only a good sign carries signature words.
   a_zero_outs: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_SIGNED) |-> (rsp_out_first == 32'd0) &&
      (rsp_out_second == 32'd0))
      else $error("nonzero signature on non-sign status");

   // Status codes stay within the defined set.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= ST_NONCE))
      else $error("undefined status code");

   // Launch no arithmetic while idle.
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !unit_cmd.start)
      else $error("arithmetic launched while idle");

   // A request is always followed by its check step.
   a_accept_check: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> (state_ff == S_CHECK))
      else $error("accepted request skipped check");

endmodule

FILE: sim/tb.sv
// Self-checking testbench for the ElGamal sign and verify engine.
`timescale 1ns / 1ps
module tb;
   import esv_pkg::*;

   // Watchdog limit on the whole run, with a wide margin over all words.
   localparam int CYCLE_LIMIT = 4000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_opcode = OPC_SIGN;
   logic [31:0] req_message = '0;
   logic [31:0] req_sig_first = '0;
   logic [31:0] req_sig_second = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_out_first;
   logic [31:0] rsp_out_second;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_MODULUS;
   logic [31:0] csr_wdata = '0;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] first;
      logic [31:0] second;
   } sig_result_type;

   sig_result_type expected_results[$];
   logic [31:0] cfg_p, cfg_g, cfg_d, cfg_r;
   int          error_count = 0;
   longint      cycle_count = 0;
   bit          idle_enable = 1'b1;

   elgamal_sign_verify dut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   // ---- modular arithmetic of the predictor, all at 64 bits ----
   function automatic logic [63:0] mulmod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
      return (a * b) % m;
   endfunction

   function automatic logic [63:0] powmod(logic [63:0] base, logic [63:0] e, logic [63:0] m);
      logic [63:0] acc;
      acc = 64'd1 % m;
      base = base % m;
      while (e != '0) begin
         if (e[0]) acc = mulmod(acc, base, m);
         base = mulmod(base, base, m);
         e = e >> 1;
      end
      return acc;
   endfunction

   // Inverse of a modulo m; ok is low when gcd(a, m) is not one.
   function automatic logic [63:0] invmod(logic [63:0] a, logic [63:0] m, output bit ok);
      logic [63:0] r0, r1, r2, q, t0, t1, t2;
      r0 = m; r1 = a % m; t0 = '0; t1 = 64'd1 % m;
      while (r1 != '0) begin
         q = r0 / r1;
         r2 = r0 - q * r1;
         t2 = (t0 + m - mulmod(q % m, t1, m)) % m;
         r0 = r1; r1 = r2; t0 = t1; t1 = t2;
      end
      ok = (r0 == 64'd1);
      return t0;
   endfunction

   function automatic sig_result_type predict_signature(logic op, logic [31:0] msg,
                                                        logic [31:0] s1, logic [31:0] s2);
      sig_result_type res;
      logic [63:0] p, g, d, r, m, e1, e2nd, pm1, rinv, x1, a, b, o2, v1, v2, e2;
      bit ok;
      res = '0;
      p = {32'd0, cfg_p};
      g = {32'd0, cfg_g};
      d = {32'd0, cfg_d};
      r = {32'd0, cfg_r};
      m = {32'd0, msg};
      e1 = {32'd0, s1};
      e2nd = {32'd0, s2};
      if (op == OPC_SIGN) begin
         res.status = ST_NONCE;
         if (p >= 64'd3) begin
            pm1 = p - 64'd1;
            rinv = invmod(r, pm1, ok);
            if (ok) begin
               x1 = powmod(g, r, p);
               a = m % pm1;
               b = mulmod(d % pm1, x1 % pm1, pm1);
               o2 = mulmod((a + pm1 - b) % pm1, rinv, pm1);
               res.status = ST_SIGNED;
               res.first = x1[31:0];
               res.second = o2[31:0];
            end
         end
      end else if (p < 64'd3 || e1 == '0 || e1 >= p || e2nd == '0 || e2nd >= p - 64'd1) begin
         res.status = ST_RANGE;
      end else begin
         e2 = powmod(g, d, p);
         v1 = powmod(g, m, p);
         v2 = mulmod(powmod(e2, e1, p), powmod(e1, e2nd, p), p);
         res.status = (v1 == v2) ? ST_ACCEPT : ST_DENY;
      end
      return res;
   endfunction

   // ---- watchdog ----
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[elgamal_sign_verify] ERROR");
         $finish;
      end
   end

   // ---- result checker: compare each accepted word with the oldest expectation ----
   always @(posedge clock) begin
      sig_result_type exp_res;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $error("unexpected result word: status %0d", rsp_status);
            error_count++;
         end else begin
            exp_res = expected_results.pop_front();
            if (rsp_status !== exp_res.status) begin
               $error("status: expected %0d, actual %0d", exp_res.status, rsp_status);
               error_count++;
            end
            if (rsp_out_first !== exp_res.first) begin
               $error("out_first: expected %0h, actual %0h", exp_res.first, rsp_out_first);
               error_count++;
            end
            if (rsp_out_second !== exp_res.second) begin
               $error("out_second: expected %0h, actual %0h", exp_res.second,
                      rsp_out_second);
               error_count++;
            end
         end
      end
   end

   // ---- result-side stalls: random bursts, none while idling is off ----
   initial begin
      int n;
      forever begin
         @(negedge clock);
         if (idle_enable && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            n = $urandom_range(1, 15);
            repeat (n) @(negedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // Send one request word; predict its result when it is accepted.
   task automatic send_word(logic op, logic [31:0] msg, logic [31:0] s1, logic [31:0] s2);
      int n;
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         n = $urandom_range(1, 15);
         repeat (n) @(negedge clock);
      end
      req_valid = 1'b1;
      req_opcode = op;
      req_message = msg;
      req_sig_first = s1;
      req_sig_second = s2;
      do @(posedge clock); while (!req_ready);
      expected_results = {expected_results, predict_signature(op, msg, s1, s2)};
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // Wait until every result is back, then let the engine settle.
   task automatic drain();
      while (expected_results.size() != 0) @(negedge clock);
      repeat (50) @(negedge clock);
   endtask

   // Write one register; only called while the engine is idle.
   task automatic write_csr(logic [1:0] idx, logic [31:0] value);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_MODULUS:   cfg_p = value;
         CSR_GENERATOR: cfg_g = value;
         CSR_PRIV_EXP:  cfg_d = value;
         default:       cfg_r = value;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic load_key(logic [31:0] p, logic [31:0] g, logic [31:0] d, logic [31:0] r);
      drain();
      write_csr(CSR_MODULUS, p);
      write_csr(CSR_GENERATOR, g);
      write_csr(CSR_PRIV_EXP, d);
      write_csr(CSR_NONCE, r);
   endtask

   // Sign a message; when it signs, verify the predicted signature and sometimes a tampered copy.
   task automatic sign_then_verify(logic [31:0] msg);
      sig_result_type sig;
      sig = predict_signature(OPC_SIGN, msg, '0, '0);
      send_word(OPC_SIGN, msg, $urandom, $urandom);
      if (sig.status == ST_SIGNED) begin
         send_word(OPC_VERIFY, msg, sig.first, sig.second);
         if ($urandom_range(0, 1)) send_word(OPC_VERIFY, msg + 1, sig.first, sig.second);
      end
   endtask

   // Directed: reset values, field extremes, range checks, bad nonces, tiny moduli.
   task automatic test_directed();
      sign_then_verify(32'd0);
      sign_then_verify(32'hFFFF_FFFF);
      send_word(OPC_VERIFY, 32'd5, 32'd0, 32'd1);
      send_word(OPC_VERIFY, 32'd5, cfg_p, 32'd1);
      send_word(OPC_VERIFY, 32'd5, 32'd1, 32'd0);
      send_word(OPC_VERIFY, 32'd5, 32'd1, cfg_p - 1);
      send_word(OPC_VERIFY, 32'hFFFF_FFFF, cfg_p - 1, cfg_p - 2);
      // nonce sharing a factor with p-1, then a multiple of p-1
      load_key(32'd23, 32'd5, 32'd7, 32'd4);
      send_word(OPC_SIGN, 32'd9, '0, '0);
      load_key(32'd23, 32'd5, 32'd7, 32'd22);
      send_word(OPC_SIGN, 32'd9, '0, '0);
      // moduli below three
      load_key(32'd2, 32'd1, 32'd1, 32'd1);
      send_word(OPC_SIGN, 32'd3, '0, '0);
      send_word(OPC_VERIFY, 32'd3, 32'd1, 32'd1);
      load_key(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(OPC_SIGN, 32'd3, '0, '0);
      // smallest accepted prime and largest 32-bit prime
      load_key(32'd3, 32'd2, 32'd1, 32'd1);
      sign_then_verify(32'd7);
      load_key(32'hFFFF_FFFB, 32'd5, 32'hFFFF_FFF0, 32'hFFFF_FFF9);
      sign_then_verify(32'h1234_5678);
      sign_then_verify(32'hFFFF_FFFF);
   endtask

   // Random: mostly sign/verify pairs under several keys, some random verifies.
   task automatic test_random(int count);
      logic [31:0] primes[6];
      logic [31:0] p;
      int i;
      primes = '{32'd11, 32'd23, 32'd1019, 32'd65521, 32'd2147483647, 32'hFFFF_FFFB};
      i = 0;
      while (i < count) begin
         if (i % 20 == 0) begin
            p = primes[$urandom_range(0, 5)];
            load_key(p, $urandom_range(2, p - 1), $urandom, $urandom | 32'd1);
         end
         if ($urandom_range(0, 3) != 0) begin
            sign_then_verify($urandom);
            i += 2;
         end else begin
            send_word(OPC_VERIFY, $urandom, $urandom_range(0, p), $urandom_range(0, p));
            i += 1;
         end
      end
   endtask

   initial begin
      cfg_p = RST_MODULUS;
      cfg_g = RST_GENERATOR;
      cfg_d = RST_PRIV_EXP;
      cfg_r = RST_NONCE;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(55);
      // last stretch runs with no idling on either side
      idle_enable = 1'b0;
      test_random(15);
      drain();
      if (error_count == 0) begin
         $display("[elgamal_sign_verify] OK");
      end else begin
         $display("[elgamal_sign_verify] ERROR");
      end
      $finish;
   end
endmodule
